[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg: shared types, constants and functions of the source token scanner
// Holds the token kinds, the scanner modes, the keyword table and the small
// per-character scanning functions used by the top level.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int POS_BITS     = 24;
	localparam int COL_BITS     = 16;
	localparam int KIND_BITS    = 6;
	localparam int ERR_BITS     = 2;
	localparam int RES_DEPTH    = 8;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = RES_PTR_BITS + 1;
	localparam int MAX_RES      = 3;
	localparam int PREFIX_BYTES = 6;
	localparam int NUM_KW       = 12;

	typedef logic [POS_BITS-1:0]     pos_t;
	typedef logic [COL_BITS-1:0]     col_t;
	typedef logic [KIND_BITS-1:0]    kind_t;
	typedef logic [ERR_BITS-1:0]     err_t;
	typedef logic [RES_PTR_BITS-1:0] res_ptr_t;
	typedef logic [RES_CNT_BITS-1:0] res_cnt_t;
	typedef logic [2:0]              wlen_t;
	typedef logic [PREFIX_BYTES-1:0][7:0] prefix_t;

	typedef enum logic [12:0] {
		M_IDLE    = 13'b0000000000001,
		M_IDENT   = 13'b0000000000010,
		M_INT     = 13'b0000000000100,
		M_NUMDOT  = 13'b0000000001000,
		M_FLOAT   = 13'b0000000010000,
		M_STRING  = 13'b0000000100000,
		M_COMMENT = 13'b0000001000000,
		M_MINUS   = 13'b0000010000000,
		M_BANG    = 13'b0000100000000,
		M_EQ      = 13'b0001000000000,
		M_LT      = 13'b0010000000000,
		M_GT      = 13'b0100000000000,
		M_SLASH   = 13'b1000000000000
	} scan_mode_t;

	localparam kind_t K_EOF     = 6'd0;
	localparam kind_t K_LPAREN  = 6'd1;
	localparam kind_t K_RPAREN  = 6'd2;
	localparam kind_t K_LBRACE  = 6'd3;
	localparam kind_t K_RBRACE  = 6'd4;
	localparam kind_t K_LBRACK  = 6'd5;
	localparam kind_t K_RBRACK  = 6'd6;
	localparam kind_t K_SEMI    = 6'd7;
	localparam kind_t K_COMMA   = 6'd8;
	localparam kind_t K_DOT     = 6'd9;
	localparam kind_t K_COLON   = 6'd10;
	localparam kind_t K_MINUS   = 6'd11;
	localparam kind_t K_ARROW   = 6'd12;
	localparam kind_t K_PLUS    = 6'd13;
	localparam kind_t K_SLASH   = 6'd14;
	localparam kind_t K_STAR    = 6'd15;
	localparam kind_t K_BANG    = 6'd16;
	localparam kind_t K_BANGEQ  = 6'd17;
	localparam kind_t K_EQ      = 6'd18;
	localparam kind_t K_EQEQ    = 6'd19;
	localparam kind_t K_LT      = 6'd20;
	localparam kind_t K_LE      = 6'd21;
	localparam kind_t K_GT      = 6'd22;
	localparam kind_t K_GE      = 6'd23;
	localparam kind_t K_STRING  = 6'd24;
	localparam kind_t K_INT     = 6'd25;
	localparam kind_t K_FLOAT   = 6'd26;
	localparam kind_t K_IDENT   = 6'd27;
	localparam kind_t K_KW_BASE = 6'd28;
	localparam kind_t K_ERROR   = 6'd40;

	localparam err_t E_NONE       = 2'd0;
	localparam err_t E_UNEXPECTED = 2'd1;
	localparam err_t E_UNTERM     = 2'd2;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keyword spellings with the first character in the lowest byte.
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h000000646e61,  // and
		48'h000065736c65,  // else
		48'h0065736c6166,  // false
		48'h000000006e66,  // fn
		48'h000000726f66,  // for
		48'h000000006669,  // if
		48'h00000074656c,  // let
		48'h00000000726f,  // or
		48'h6e7275746572,  // return
		48'h746375727473,  // struct
		48'h000065757274,  // true
		48'h00656c696877   // while
	};
	localparam wlen_t KW_LEN [NUM_KW] = '{
		3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd2, 3'd3, 3'd2, 3'd6, 3'd6, 3'd4, 3'd5
	};

	typedef struct packed {
		pos_t line;
		col_t col;
		pos_t off;
		pos_t tso;
		col_t tsc;
	} pos_state_t;

	typedef struct packed {
		kind_t kind;
		err_t  err;
		pos_t  start_offset;
		pos_t  length;
		pos_t  line;
		col_t  start_col;
		col_t  end_col;
	} token_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} res_entry_t;

	typedef struct packed {
		pos_state_t pos;
		scan_mode_t mode;
		logic       emit;
		token_t     tok;
		logic       word;
	} idle_res_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Column and offset step by one and stop at their maximum.
	function automatic pos_state_t advance(input pos_state_t p);
		pos_state_t r;
		r = p;
		if (p.col != '1) begin
			r.col = col_t'(p.col + 1'b1);
		end
		if (p.off != '1) begin
			r.off = pos_t'(p.off + 1'b1);
		end
		return r;
	endfunction

	function automatic pos_state_t newline(input pos_state_t p);
		pos_state_t r;
		r = p;
		if (p.line != '1) begin
			r.line = pos_t'(p.line + 1'b1);
		end
		r.col = '0;
		return advance(r);
	endfunction

	function automatic token_t make_token(input pos_state_t p, input kind_t k, input err_t e);
		token_t t;
		t.kind         = k;
		t.err          = e;
		t.start_offset = p.tso;
		t.length       = (p.off >= p.tso) ? pos_t'(p.off - p.tso) : '0;
		t.line         = p.line;
		t.start_col    = p.tsc;
		t.end_col      = p.col;
		return t;
	endfunction

	function automatic kind_t word_kind(input prefix_t pfx, input wlen_t wlen);
		kind_t k;
		logic  hit;
		k = K_IDENT;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			hit = (wlen == KW_LEN[i]);
			for (int j = 0; j < PREFIX_BYTES; j++) begin
				if (j < int'(KW_LEN[i]) && pfx[j] != KW_TEXT[i][8*j +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				k = kind_t'(K_KW_BASE + kind_t'(i));
			end
		end
		return k;
	endfunction

	// Kind of a pending operator character when no pair is formed.
	function automatic kind_t single_kind(input scan_mode_t m);
		kind_t k;
		case (m)
			M_MINUS: k = K_MINUS;
			M_BANG:  k = K_BANG;
			M_EQ:    k = K_EQ;
			M_LT:    k = K_LT;
			M_GT:    k = K_GT;
			default: k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(input scan_mode_t m);
		kind_t k;
		case (m)
			M_BANG:  k = K_BANGEQ;
			M_EQ:    k = K_EQEQ;
			M_LT:    k = K_LE;
			default: k = K_GE;
		endcase
		return k;
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_SEMI:   k = K_SEMI;
			CH_COMMA:  k = K_COMMA;
			CH_DOT:    k = K_DOT;
			CH_COLON:  k = K_COLON;
			CH_PLUS:   k = K_PLUS;
			CH_STAR:   k = K_STAR;
			default:   k = K_ERROR;
		endcase
		return k;
	endfunction

	// One character seen between tokens: skip blanks, open a token, or
	// emit a single-character token straight away.
	function automatic idle_res_t idle_scan(input pos_state_t p, input logic [7:0] c);
		idle_res_t r;
		kind_t     k;
		r.pos  = p;
		r.mode = M_IDLE;
		r.emit = 1'b0;
		r.tok  = '0;
		r.word = 1'b0;
		k      = punct_kind(c);
		if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
			r.pos = advance(p);
		end else if (c == CH_LF) begin
			r.pos = newline(p);
		end else begin
			r.pos.tso = p.off;
			r.pos.tsc = p.col;
			r.pos     = advance(r.pos);
			if (is_alpha(c) || c == CH_USCORE) begin
				r.mode = M_IDENT;
				r.word = 1'b1;
			end else if (is_digit(c)) begin
				r.mode = M_INT;
			end else begin
				case (c)
					CH_DQUOTE: r.mode = M_STRING;
					CH_MINUS:  r.mode = M_MINUS;
					CH_BANG:   r.mode = M_BANG;
					CH_EQ:     r.mode = M_EQ;
					CH_LT:     r.mode = M_LT;
					CH_GT:     r.mode = M_GT;
					CH_SLASH:  r.mode = M_SLASH;
					default: begin
						r.emit = 1'b1;
						r.tok  = make_token(r.pos, k,
							(k == K_ERROR) ? E_UNEXPECTED : E_NONE);
					end
				endcase
			end
		end
		return r;
	endfunction

endpackage

[rtl/source_token_scanner.sv]
// ----------------------------------------------------------------------------
// source_token_scanner: lexical scanner for a small C-like language
// Takes source text one byte per word and emits one word per token.
// ----------------------------------------------------------------------------
// The scanner accepts one source byte, or an end-of-source marker, per clock
// and returns tokens with their kind, error code, start offset, length, line
// and start and end columns. An accepted word is held in an input register,
// classified against the scanner state in a single pass of logic, and its
// tokens (none, one, two or three) are written together into an eight-entry
// result queue that feeds the output port. While tok_stall is low the output
// port delivers one token per cycle and, if each input word yields at most
// one token, a byte is taken every cycle; words that release two or three
// tokens (a token ended by a one-byte token, a number, a dot and one more
// character, or an end marker after an open token) come out one at a time.
// The input side stalls only when the result queue has fewer than three free
// entries. One character of lookahead is kept for two-character operators,
// comments and a dot after a number. The end marker flushes any open token,
// then emits an end-of-file token, and scanning carries on afterwards with
// the counters kept. Line, column and offset counters saturate at their
// maximum. last_of_run marks the final token released by a given input word.
module source_token_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  logic                            req_type,
	input  logic [7:0]                      char_byte,
	output logic                            tok_valid,
	input  logic                            tok_stall,
	output logic [sts_pkg::KIND_BITS-1:0]   token_kind,
	output logic [sts_pkg::ERR_BITS-1:0]    error_code,
	output logic [sts_pkg::POS_BITS-1:0]    start_offset,
	output logic [sts_pkg::POS_BITS-1:0]    token_length,
	output logic [sts_pkg::POS_BITS-1:0]    line_number,
	output logic [sts_pkg::COL_BITS-1:0]    start_column,
	output logic [sts_pkg::COL_BITS-1:0]    end_column,
	output logic                            last_of_run
);

	// Input register stage.
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] char_s1;
	logic       go_s1;

	// Scanner state.
	sts_pkg::scan_mode_t mode_q;
	sts_pkg::pos_state_t pos_q;
	sts_pkg::prefix_t    word_prefix_q;
	sts_pkg::wlen_t      wlen_q;

	// Result queue.
	sts_pkg::res_entry_t res_q [sts_pkg::RES_DEPTH];
	sts_pkg::res_ptr_t   wr_ptr_q;
	sts_pkg::res_ptr_t   rd_ptr_q;
	sts_pkg::res_cnt_t   cnt_q;
	sts_pkg::res_cnt_t   push_n;
	sts_pkg::res_cnt_t   pop_n;

	// Results of the scanning pass.
	sts_pkg::scan_mode_t mode_c;
	sts_pkg::pos_state_t pos_c;
	sts_pkg::wlen_t      wlen_c;
	sts_pkg::token_t     toks_c [sts_pkg::MAX_RES];
	logic [1:0]          n_c;
	logic                pfx_we_c;
	sts_pkg::wlen_t      pfx_idx_c;
	logic [7:0]          pfx_data_c;
	logic                do_dot_c;
	logic                do_idle_c;
	sts_pkg::idle_res_t  ir_c;

	// The item in the input register moves on when the queue can take the
	// worst case of three tokens.
	assign go_s1     = valid_s1 &&
		(cnt_q <= sts_pkg::res_cnt_t'(sts_pkg::RES_DEPTH - sts_pkg::MAX_RES));
	assign src_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			req_s1  <= req_type;
			char_s1 <= char_byte;
		end
	end

	// Single scanning pass. The first phase handles the pending token of the
	// current mode, the second rescans a held dot and then the new character
	// from the idle state, and the last phase adds the end-of-file token.
	always_comb begin
		mode_c     = mode_q;
		pos_c      = pos_q;
		wlen_c     = wlen_q;
		n_c        = 2'd0;
		pfx_we_c   = 1'b0;
		pfx_idx_c  = wlen_q;
		pfx_data_c = char_s1;
		do_dot_c   = 1'b0;
		do_idle_c  = 1'b0;
		ir_c       = '0;
		for (int i = 0; i < sts_pkg::MAX_RES; i++) begin
			toks_c[i] = '0;
		end

		if (req_s1 == sts_pkg::REQ_END) begin
			case (mode_q)
				sts_pkg::M_IDENT: begin
					toks_c[0] = sts_pkg::make_token(pos_q,
						sts_pkg::word_kind(word_prefix_q, wlen_q), sts_pkg::E_NONE);
					n_c = 2'd1;
				end
				sts_pkg::M_INT: begin
					toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_INT, sts_pkg::E_NONE);
					n_c = 2'd1;
				end
				sts_pkg::M_NUMDOT: begin
					toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_INT, sts_pkg::E_NONE);
					n_c = 2'd1;
					do_dot_c = 1'b1;
				end
				sts_pkg::M_FLOAT: begin
					toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_FLOAT,
						sts_pkg::E_NONE);
					n_c = 2'd1;
				end
				sts_pkg::M_STRING: begin
					toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_ERROR,
						sts_pkg::E_UNTERM);
					n_c = 2'd1;
				end
				sts_pkg::M_MINUS, sts_pkg::M_BANG, sts_pkg::M_EQ, sts_pkg::M_LT,
				sts_pkg::M_GT, sts_pkg::M_SLASH: begin
					toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::single_kind(mode_q),
						sts_pkg::E_NONE);
					n_c = 2'd1;
				end
				default: begin
				end
			endcase
		end else begin
			case (mode_q)
				sts_pkg::M_IDENT: begin
					if (sts_pkg::is_alpha(char_s1) || sts_pkg::is_digit(char_s1) ||
						char_s1 == sts_pkg::CH_USCORE) begin
						pos_c    = sts_pkg::advance(pos_q);
						pfx_we_c = (wlen_q < sts_pkg::wlen_t'(sts_pkg::PREFIX_BYTES));
						if (wlen_q != 3'd7) begin
							wlen_c = sts_pkg::wlen_t'(wlen_q + 1'b1);
						end
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q,
							sts_pkg::word_kind(word_prefix_q, wlen_q), sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_INT: begin
					if (sts_pkg::is_digit(char_s1)) begin
						pos_c = sts_pkg::advance(pos_q);
					end else if (char_s1 == sts_pkg::CH_DOT) begin
						// The dot is held back until the next character shows
						// whether a fraction follows.
						mode_c = sts_pkg::M_NUMDOT;
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_INT,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_NUMDOT: begin
					if (sts_pkg::is_digit(char_s1)) begin
						pos_c  = sts_pkg::advance(sts_pkg::advance(pos_q));
						mode_c = sts_pkg::M_FLOAT;
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_INT,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_dot_c  = 1'b1;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_FLOAT: begin
					if (sts_pkg::is_digit(char_s1)) begin
						pos_c = sts_pkg::advance(pos_q);
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_FLOAT,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_STRING: begin
					if (char_s1 == sts_pkg::CH_DQUOTE) begin
						pos_c     = sts_pkg::advance(pos_q);
						toks_c[0] = sts_pkg::make_token(pos_c, sts_pkg::K_STRING,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
					end else if (char_s1 == sts_pkg::CH_LF) begin
						pos_c = sts_pkg::newline(pos_q);
					end else begin
						pos_c = sts_pkg::advance(pos_q);
					end
				end
				sts_pkg::M_COMMENT: begin
					if (char_s1 == sts_pkg::CH_LF) begin
						pos_c  = sts_pkg::newline(pos_q);
						mode_c = sts_pkg::M_IDLE;
					end else begin
						pos_c = sts_pkg::advance(pos_q);
					end
				end
				sts_pkg::M_MINUS: begin
					if (char_s1 == sts_pkg::CH_GT) begin
						pos_c     = sts_pkg::advance(pos_q);
						toks_c[0] = sts_pkg::make_token(pos_c, sts_pkg::K_ARROW,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_MINUS,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_BANG, sts_pkg::M_EQ, sts_pkg::M_LT, sts_pkg::M_GT: begin
					if (char_s1 == sts_pkg::CH_EQ) begin
						pos_c     = sts_pkg::advance(pos_q);
						toks_c[0] = sts_pkg::make_token(pos_c, sts_pkg::pair_kind(mode_q),
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q,
							sts_pkg::single_kind(mode_q), sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				sts_pkg::M_SLASH: begin
					if (char_s1 == sts_pkg::CH_SLASH) begin
						pos_c  = sts_pkg::advance(pos_q);
						mode_c = sts_pkg::M_COMMENT;
					end else begin
						toks_c[0] = sts_pkg::make_token(pos_q, sts_pkg::K_SLASH,
							sts_pkg::E_NONE);
						n_c       = 2'd1;
						mode_c    = sts_pkg::M_IDLE;
						do_idle_c = 1'b1;
					end
				end
				default: begin
					mode_c    = sts_pkg::M_IDLE;
					do_idle_c = 1'b1;
				end
			endcase
		end

		// A dot held after a number becomes a token of its own.
		if (do_dot_c) begin
			ir_c      = sts_pkg::idle_scan(pos_c, sts_pkg::CH_DOT);
			pos_c     = ir_c.pos;
			mode_c    = ir_c.mode;
			toks_c[n_c] = ir_c.tok;
			n_c       = 2'(n_c + 2'd1);
		end

		if (do_idle_c) begin
			ir_c   = sts_pkg::idle_scan(pos_c, char_s1);
			pos_c  = ir_c.pos;
			mode_c = ir_c.mode;
			if (ir_c.emit) begin
				toks_c[n_c] = ir_c.tok;
				n_c         = 2'(n_c + 2'd1);
			end
			if (ir_c.word) begin
				pfx_we_c  = 1'b1;
				pfx_idx_c = '0;
				wlen_c    = 3'd1;
			end
		end

		if (req_s1 == sts_pkg::REQ_END) begin
			mode_c      = sts_pkg::M_IDLE;
			pos_c.tso   = pos_c.off;
			pos_c.tsc   = pos_c.col;
			toks_c[n_c] = sts_pkg::make_token(pos_c, sts_pkg::K_EOF, sts_pkg::E_NONE);
			n_c         = 2'(n_c + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= sts_pkg::M_IDLE;
			pos_q.line <= sts_pkg::pos_t'(1);
			pos_q.col  <= sts_pkg::col_t'(1);
			pos_q.off  <= '0;
			pos_q.tso  <= '0;
			pos_q.tsc  <= sts_pkg::col_t'(1);
			wlen_q     <= '0;
		end else if (go_s1) begin
			mode_q <= mode_c;
			pos_q  <= pos_c;
			wlen_q <= wlen_c;
		end
	end

	// The identifier prefix is only read up to the stored length.
	always_ff @(posedge clk) begin
		if (go_s1 && pfx_we_c) begin
			word_prefix_q[pfx_idx_c[2:0]] <= pfx_data_c;
		end
	end

	// Result queue: up to three tokens are written per cycle, and one is read when tok_stall is low.
	assign push_n    = go_s1 ? sts_pkg::res_cnt_t'(n_c) : '0;
	assign tok_valid = (cnt_q != '0);
	assign pop_n     = sts_pkg::res_cnt_t'(tok_valid && !tok_stall);

	always_ff @(posedge clk) begin
		for (int i = 0; i < sts_pkg::MAX_RES; i++) begin
			if (go_s1 && 2'(i) < n_c) begin
				res_q[sts_pkg::res_ptr_t'(wr_ptr_q + sts_pkg::res_ptr_t'(i))] <=
					'{tok: toks_c[i], last: (2'(i) == 2'(n_c - 2'd1))};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= sts_pkg::res_ptr_t'(wr_ptr_q + push_n[sts_pkg::RES_PTR_BITS-1:0]);
			rd_ptr_q <= sts_pkg::res_ptr_t'(rd_ptr_q + pop_n[sts_pkg::RES_PTR_BITS-1:0]);
			cnt_q    <= sts_pkg::res_cnt_t'(cnt_q + push_n - pop_n);
		end
	end

	assign token_kind   = res_q[rd_ptr_q].tok.kind;
	assign error_code   = res_q[rd_ptr_q].tok.err;
	assign start_offset = res_q[rd_ptr_q].tok.start_offset;
	assign token_length = res_q[rd_ptr_q].tok.length;
	assign line_number  = res_q[rd_ptr_q].tok.line;
	assign start_column = res_q[rd_ptr_q].tok.start_col;
	assign end_column   = res_q[rd_ptr_q].tok.end_col;
	assign last_of_run  = res_q[rd_ptr_q].last;

	// The queue never overfills.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sts_pkg::res_cnt_t'(sts_pkg::RES_DEPTH))
		else $error("result queue overfilled");

	// The fill count follows the pushes and pops of the previous cycle.
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == sts_pkg::res_cnt_t'($past(cnt_q) + $past(push_n) - $past(pop_n)))
		else $error("result queue count out of step");

	// An end marker always releases at least the end-of-file token and
	// leaves the scanner between tokens.
	a_end_push: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && req_s1 == sts_pkg::REQ_END |-> push_n != '0)
		else $error("end marker released no token");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && req_s1 == sts_pkg::REQ_END |=> mode_q == sts_pkg::M_IDLE)
		else $error("scanner not idle after end marker");

	// The line counter starts at one and never wraps back to zero.
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.line != '0)
		else $error("line counter reached zero");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the source token scanner
// Feeds source bytes and end markers through the input handshake, predicts
// every token with an independent scanner model kept in step with the
// accepted words, and compares each token leaving the block field by field.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sts_pkg::*;

	// Idle cycles in a row after which the run is declared hung. The longest
	// legitimate quiet stretch is the receiver hold-off below.
	localparam int HANG_LIMIT    = 2000;
	localparam int HOLDOFF_LEN   = 300;
	localparam int HOLDOFF_AFTER = 150;
	localparam int RANDOM_WORDS  = 470;
	localparam int DRAIN_AT      = 250;
	localparam int LONG_WORD_LEN = 65600;

	typedef enum logic [1:0] {
		ENTRY_WORD,
		ENTRY_DRAIN,
		ENTRY_STEADY
	} entry_kind_t;

	typedef struct {
		entry_kind_t what;
		logic        req;
		logic [7:0]  ch;
	} source_entry_t;

	typedef struct packed {
		kind_t kind;
		err_t  err;
		pos_t  start;
		pos_t  length;
		pos_t  line;
		col_t  first_col;
		col_t  end_col;
		logic  last;
	} scanned_token_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       src_valid   = 1'b0;
	logic       src_stall;
	logic       req_type    = REQ_BYTE;
	logic [7:0] char_byte   = 8'h00;
	logic       tok_valid;
	logic       tok_stall   = 1'b0;
	kind_t      token_kind;
	err_t       error_code;
	pos_t       start_offset;
	pos_t       token_length;
	pos_t       line_number;
	col_t       start_column;
	col_t       end_column;
	logic       last_of_run;

	source_token_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.error_code   (error_code),
		.start_offset (start_offset),
		.token_length (token_length),
		.line_number  (line_number),
		.start_column (start_column),
		.end_column   (end_column),
		.last_of_run  (last_of_run)
	);

	// Keyword spellings in the order of their token kinds.
	string keyword_spelling [12] = '{
		"and", "else", "false", "fn", "for", "if",
		"let", "or", "return", "struct", "true", "while"
	};
	string single_ops = "()[]{};,.:+*-!=<>/";
	string pair_ops [5] = '{"->", "!=", "==", "<=", ">="};

	source_entry_t  source_queue [$];
	scanned_token_t expected_tokens [$];
	scanned_token_t word_tokens [$];

	int   words_queued    = 0;
	int   words_accepted  = 0;
	int   mismatch_count  = 0;
	logic steady_phase    = 1'b0;
	logic drain_wait      = 1'b0;
	int   send_gap        = 0;
	int   send_quiet      = 0;
	int   recv_gap        = 0;
	int   recv_quiet      = 0;
	int   holdoff_left    = 0;
	logic holdoff_done    = 1'b0;
	int   idle_cycles     = 0;

	// ------------------------------------------------------------------
	// Scanner prediction. The state mirrors the block: mode, the running
	// position, the position where the open token began, and the first six
	// bytes of an open identifier with its length (seven means longer).
	// ------------------------------------------------------------------
	scan_mode_t  scan_state  = M_IDLE;
	pos_t        line_now    = 1;
	col_t        column_now  = 1;
	pos_t        offset_now  = 0;
	pos_t        tok_offset  = 0;
	col_t        tok_column  = 1;
	logic [7:0]  word_head [6] = '{default: 8'h00};
	logic [2:0]  word_len    = 0;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Column and offset both stop at their all-ones value.
	function automatic void step_position();
		if (column_now != '1) column_now = column_now + 1'b1;
		if (offset_now != '1) offset_now = offset_now + 1'b1;
	endfunction

	// The column is cleared so that the byte after the line feed is column 1.
	function automatic void start_new_line();
		if (line_now != '1) line_now = line_now + 1'b1;
		column_now = '0;
		step_position();
	endfunction

	function automatic void record_token(input kind_t k, input err_t e);
		scanned_token_t t;
		if (word_tokens.size() >= MAX_RES) return;
		t.kind      = k;
		t.err       = e;
		t.start     = tok_offset;
		t.length    = (offset_now >= tok_offset) ? pos_t'(offset_now - tok_offset) : '0;
		t.line      = line_now;
		t.first_col = tok_column;
		t.end_col   = column_now;
		t.last      = 1'b0;
		word_tokens.push_back(t);
	endfunction

	// An identifier is a keyword only when its whole spelling matches, so a
	// word longer than six bytes can never be one.
	function automatic kind_t keyword_or_ident();
		kind_t k;
		bit    hit;
		k = K_IDENT;
		for (int i = 0; i < 12; i++) begin
			if (k == K_IDENT && int'(word_len) == keyword_spelling[i].len()) begin
				hit = 1'b1;
				for (int j = 0; j < keyword_spelling[i].len(); j++) begin
					if (word_head[j] != keyword_spelling[i].getc(j)) hit = 1'b0;
				end
				if (hit) k = kind_t'(K_KW_BASE + i);
			end
		end
		return k;
	endfunction

	function automatic kind_t lone_operator_kind(input scan_mode_t m);
		case (m)
			M_MINUS: return K_MINUS;
			M_BANG:  return K_BANG;
			M_EQ:    return K_EQ;
			M_LT:    return K_LT;
			M_GT:    return K_GT;
			default: return K_SLASH;
		endcase
	endfunction

	// A byte seen with no token open.
	function automatic void scan_between(input logic [7:0] c);
		if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
			step_position();
			return;
		end
		if (c == CH_LF) begin
			start_new_line();
			return;
		end
		tok_offset = offset_now;
		tok_column = column_now;
		step_position();
		if (is_letter(c) || c == CH_USCORE) begin
			word_head[0] = c;
			word_len     = 3'd1;
			scan_state   = M_IDENT;
			return;
		end
		if (is_numeral(c)) begin
			scan_state = M_INT;
			return;
		end
		case (c)
			CH_LPAREN: record_token(K_LPAREN, E_NONE);
			CH_RPAREN: record_token(K_RPAREN, E_NONE);
			CH_LBRACE: record_token(K_LBRACE, E_NONE);
			CH_RBRACE: record_token(K_RBRACE, E_NONE);
			CH_LBRACK: record_token(K_LBRACK, E_NONE);
			CH_RBRACK: record_token(K_RBRACK, E_NONE);
			CH_SEMI:   record_token(K_SEMI, E_NONE);
			CH_COMMA:  record_token(K_COMMA, E_NONE);
			CH_DOT:    record_token(K_DOT, E_NONE);
			CH_COLON:  record_token(K_COLON, E_NONE);
			CH_PLUS:   record_token(K_PLUS, E_NONE);
			CH_STAR:   record_token(K_STAR, E_NONE);
			CH_DQUOTE: scan_state = M_STRING;
			CH_MINUS:  scan_state = M_MINUS;
			CH_BANG:   scan_state = M_BANG;
			CH_EQ:     scan_state = M_EQ;
			CH_LT:     scan_state = M_LT;
			CH_GT:     scan_state = M_GT;
			CH_SLASH:  scan_state = M_SLASH;
			default:   record_token(K_ERROR, E_UNEXPECTED);
		endcase
	endfunction

	// Works out the tokens of one accepted word and queues them in order.
	function automatic void predict_word(input logic req, input logic [7:0] c);
		word_tokens.delete();
		if (req == REQ_END) begin
			case (scan_state)
				M_IDENT:  record_token(keyword_or_ident(), E_NONE);
				M_INT:    record_token(K_INT, E_NONE);
				M_NUMDOT: begin
					// The held dot becomes a token of its own.
					record_token(K_INT, E_NONE);
					scan_state = M_IDLE;
					scan_between(CH_DOT);
				end
				M_FLOAT:  record_token(K_FLOAT, E_NONE);
				M_STRING: record_token(K_ERROR, E_UNTERM);
				M_IDLE, M_COMMENT: ;
				default:  record_token(lone_operator_kind(scan_state), E_NONE);
			endcase
			scan_state = M_IDLE;
			tok_offset = offset_now;
			tok_column = column_now;
			record_token(K_EOF, E_NONE);
		end else begin
			case (scan_state)
				M_IDENT: begin
					if (is_letter(c) || is_numeral(c) || c == CH_USCORE) begin
						step_position();
						if (word_len < 3'd6) word_head[word_len] = c;
						if (word_len < 3'd7) word_len = word_len + 1'b1;
					end else begin
						record_token(keyword_or_ident(), E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				M_INT: begin
					if (is_numeral(c)) begin
						step_position();
					end else if (c == CH_DOT) begin
						scan_state = M_NUMDOT;
					end else begin
						record_token(K_INT, E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				M_NUMDOT: begin
					if (is_numeral(c)) begin
						step_position();
						step_position();
						scan_state = M_FLOAT;
					end else begin
						record_token(K_INT, E_NONE);
						scan_state = M_IDLE;
						scan_between(CH_DOT);
						scan_between(c);
					end
				end
				M_FLOAT: begin
					if (is_numeral(c)) begin
						step_position();
					end else begin
						record_token(K_FLOAT, E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				M_STRING: begin
					if (c == CH_DQUOTE) begin
						step_position();
						record_token(K_STRING, E_NONE);
						scan_state = M_IDLE;
					end else if (c == CH_LF) begin
						start_new_line();
					end else begin
						step_position();
					end
				end
				M_COMMENT: begin
					if (c == CH_LF) begin
						scan_state = M_IDLE;
						start_new_line();
					end else begin
						step_position();
					end
				end
				M_MINUS: begin
					if (c == CH_GT) begin
						step_position();
						record_token(K_ARROW, E_NONE);
						scan_state = M_IDLE;
					end else begin
						record_token(K_MINUS, E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				M_BANG, M_EQ, M_LT, M_GT: begin
					if (c == CH_EQ) begin
						step_position();
						record_token(scan_state == M_BANG ? K_BANGEQ :
							scan_state == M_EQ ? K_EQEQ :
							scan_state == M_LT ? K_LE : K_GE, E_NONE);
						scan_state = M_IDLE;
					end else begin
						record_token(lone_operator_kind(scan_state), E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						step_position();
						scan_state = M_COMMENT;
					end else begin
						record_token(K_SLASH, E_NONE);
						scan_state = M_IDLE;
						scan_between(c);
					end
				end
				default: begin
					scan_state = M_IDLE;
					scan_between(c);
				end
			endcase
		end
		if (word_tokens.size() > 0) word_tokens[word_tokens.size() - 1].last = 1'b1;
		foreach (word_tokens[i]) expected_tokens.push_back(word_tokens[i]);
	endfunction

	// ------------------------------------------------------------------
	// Source text generation.
	// ------------------------------------------------------------------
	task automatic add_char(input logic [7:0] c);
		source_queue.push_back('{ENTRY_WORD, REQ_BYTE, c});
		words_queued++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_char(s.getc(i));
	endtask

	// The byte lane carries random junk with an end marker; it must be ignored.
	task automatic add_end();
		source_queue.push_back('{ENTRY_WORD, REQ_END, 8'($urandom_range(0, 255))});
		words_queued++;
	endtask

	task automatic add_marker(input entry_kind_t what);
		source_queue.push_back('{what, REQ_BYTE, 8'h00});
	endtask

	function automatic logic [7:0] ident_char();
		case ($urandom_range(0, 3))
			0:       return 8'("a" + $urandom_range(0, 25));
			1:       return 8'("A" + $urandom_range(0, 25));
			2:       return 8'("0" + $urandom_range(0, 9));
			default: return CH_USCORE;
		endcase
	endfunction

	task automatic add_digits(input int count);
		repeat (count) add_char(8'("0" + $urandom_range(0, 9)));
	endtask

	// Mostly well-formed lexemes with random content, with some noise bytes,
	// unterminated strings and comments, and end markers in awkward places.
	task automatic add_random_lexeme();
		logic [7:0] c;
		case ($urandom_range(0, 13))
			0, 1: begin
				c = ident_char();
				if (is_numeral(c)) c = "z";
				add_char(c);
				repeat ($urandom_range(0, 8)) add_char(ident_char());
			end
			2: begin
				// Sometimes a keyword with an extra byte, which is no keyword.
				add_text(keyword_spelling[$urandom_range(0, 11)]);
				if ($urandom_range(0, 3) == 0) add_char(ident_char());
			end
			3: add_digits($urandom_range(1, 5));
			4: begin
				add_digits($urandom_range(1, 3));
				add_char(CH_DOT);
				add_digits($urandom_range(1, 3));
			end
			5: begin
				// Trailing dot: whatever comes next decides what it becomes.
				add_digits($urandom_range(1, 3));
				add_char(CH_DOT);
			end
			6: begin
				add_char(CH_DQUOTE);
				repeat ($urandom_range(0, 6)) begin
					c = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(32, 126));
					add_char(c == CH_DQUOTE ? 8'("x") : c);
				end
				if ($urandom_range(0, 5) != 0) add_char(CH_DQUOTE);
			end
			7: begin
				add_char(CH_SLASH);
				add_char(CH_SLASH);
				repeat ($urandom_range(0, 8)) add_char(8'($urandom_range(32, 126)));
				if ($urandom_range(0, 4) != 0) add_char(CH_LF);
			end
			8: add_char(single_ops.getc($urandom_range(0, single_ops.len() - 1)));
			9: add_text(pair_ops[$urandom_range(0, 4)]);
			10: begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0:       add_char(CH_SPACE);
						1:       add_char(CH_TAB);
						2:       add_char(CH_CR);
						default: add_char(CH_LF);
					endcase
				end
			end
			11: add_char(8'($urandom_range(0, 255)));
			12: add_end();
			default: add_char(CH_SPACE);
		endcase
		if ($urandom_range(0, 1) == 0) add_char($urandom_range(0, 3) == 0 ? CH_LF : CH_SPACE);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and the script of the run.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		logic drain_placed;
		drain_placed = 1'b0;

		// Directed opening: a float, a number with a trailing dot before a
		// semicolon, an identifier, a comment closed by a line feed, an open
		// string cut off by the end marker, a zero byte and an all-ones byte
		// as unexpected characters, then a trailing dot flushed by the end
		// marker, which yields three tokens from one word.
		add_text("1.5 2.; x//c");
		add_char(CH_LF);
		add_text("\"q");
		add_end();
		add_char(8'h00);
		add_char(8'hFF);
		add_text("7.");
		add_end();

		// Random source text. Part way through, the sender holds back until
		// every token so far has come out.
		while (words_queued < RANDOM_WORDS + 21) begin
			add_random_lexeme();
			if (!drain_placed && words_queued >= DRAIN_AT) begin
				add_marker(ENTRY_DRAIN);
				drain_placed = 1'b1;
			end
		end

		// Final stretch with no idling. A very long identifier drives the
		// column counter into saturation, and the operator after it starts
		// and ends at the saturated column.
		add_end();
		add_marker(ENTRY_STEADY);
		add_char(CH_LF);
		add_char("k");
		repeat (LONG_WORD_LEN - 1) add_char(ident_char());
		add_text(" +");
		add_char(CH_LF);
		repeat (8) add_random_lexeme();
		add_end();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled on the falling edge so that the driver's work at the rising
		// edge has fully settled.
		while (source_queue.size() != 0 || src_valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender. A word on offer stays put while the block stalls; only once it
	// is taken (or nothing is offered) is the next one chosen.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || !src_stall) begin
			if (src_valid) begin
				predict_word(req_type, char_byte);
				words_accepted++;
			end

			// A drain pause ends once every predicted token has come out.
			if (drain_wait && expected_tokens.size() == 0) drain_wait = 1'b0;
			while (!drain_wait && source_queue.size() != 0 &&
				source_queue[0].what != ENTRY_WORD) begin
				if (source_queue[0].what == ENTRY_DRAIN) drain_wait = 1'b1;
				else steady_phase = 1'b1;
				void'(source_queue.pop_front());
			end

			if (send_quiet > 0) send_quiet--;
			else if (!steady_phase && $urandom_range(0, 39) == 0)
				send_quiet = $urandom_range(20, 60);

			if (drain_wait || source_queue.size() == 0) begin
				src_valid <= 1'b0;
			end else if (send_gap > 0) begin
				send_gap--;
				src_valid <= 1'b0;
			end else if (!steady_phase && send_quiet == 0 && $urandom_range(0, 5) == 0) begin
				// This cycle starts a burst of idle cycles whose remaining length is drawn into send_gap.
				send_gap = $urandom_range(0, 9);
				src_valid <= 1'b0;
			end else begin
				req_type  <= source_queue[0].req;
				char_byte <= source_queue[0].ch;
				src_valid <= 1'b1;
				void'(source_queue.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver and checker.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_token();
		scanned_token_t want;
		if (expected_tokens.size() == 0) begin
			$error("token_kind: expected no token, got %0d", token_kind);
			mismatch_count++;
		end else begin
			want = expected_tokens.pop_front();
			check_field("token_kind",   want.kind,      token_kind);
			check_field("error_code",   want.err,       error_code);
			check_field("start_offset", want.start,     start_offset);
			check_field("token_length", want.length,    token_length);
			check_field("line_number",  want.line,      line_number);
			check_field("start_column", want.first_col, start_column);
			check_field("end_column",   want.end_col,   end_column);
			check_field("last_of_run",  want.last,      last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) check_token();

			// Once, early on, the receiver stops for a long stretch while the
			// sender keeps offering, so the result queue fills and the block
			// has to stall its input.
			if (!holdoff_done && words_accepted >= HOLDOFF_AFTER) begin
				holdoff_left = HOLDOFF_LEN;
				holdoff_done = 1'b1;
			end

			if (recv_quiet > 0) recv_quiet--;
			else if (!steady_phase && $urandom_range(0, 39) == 0)
				recv_quiet = $urandom_range(20, 60);

			if (holdoff_left > 0) begin
				holdoff_left--;
				tok_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				tok_stall <= 1'b1;
			end else if (!steady_phase && recv_quiet == 0 && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 9);
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Hang detection: too many cycles in a row with no word moving on
	// either side.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
